[rtl/rcs_pkg.sv]
// Package for the robot command sequencer.
// Holds opcodes, command codes, delay constants and the sequencer flag type.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;

    localparam int CFG_BITS   = 16;
    localparam int BYTE_BITS  = 8;
    localparam int CMD_BITS   = 4;
    localparam int DELAY_BITS = 13;
    localparam int OUT_ADDR_BITS = 16;

    localparam logic [BYTE_BITS-1:0] OP_START      = 8'h01;
    localparam logic [BYTE_BITS-1:0] OP_WAIT       = 8'h02;
    localparam logic [BYTE_BITS-1:0] OP_LED_ON     = 8'h44;
    localparam logic [BYTE_BITS-1:0] OP_LED_OFF    = 8'h45;
    localparam logic [BYTE_BITS-1:0] OP_TONE       = 8'h48;
    localparam logic [BYTE_BITS-1:0] OP_TONE_STOP  = 8'h09;
    localparam logic [BYTE_BITS-1:0] OP_STOP_A     = 8'h60;
    localparam logic [BYTE_BITS-1:0] OP_STOP_B     = 8'h61;
    localparam logic [BYTE_BITS-1:0] OP_FWD        = 8'h62;
    localparam logic [BYTE_BITS-1:0] OP_REV        = 8'h63;
    localparam logic [BYTE_BITS-1:0] OP_RIGHT      = 8'h64;
    localparam logic [BYTE_BITS-1:0] OP_LEFT       = 8'h65;
    localparam logic [BYTE_BITS-1:0] OP_LOOP_BEGIN = 8'hC0;
    localparam logic [BYTE_BITS-1:0] OP_LOOP_END   = 8'hC1;
    localparam logic [BYTE_BITS-1:0] OP_END        = 8'hFF;

    localparam logic [DELAY_BITS-1:0] TURN_MS    = 13'd1000;
    localparam logic [DELAY_BITS-1:0] LED_ON_MS  = 13'd100;
    localparam logic [DELAY_BITS-1:0] LED_OFF_MS = 13'd50;

    localparam logic [BYTE_BITS-1:0] FULL_DUTY = 8'hFF;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NONE      = 4'd0,
        CMD_WAIT      = 4'd1,
        CMD_LED_ON    = 4'd2,
        CMD_LED_OFF   = 4'd3,
        CMD_TONE      = 4'd4,
        CMD_TONE_STOP = 4'd5,
        CMD_STOP      = 4'd6,
        CMD_FWD       = 4'd7,
        CMD_REV       = 4'd8,
        CMD_RIGHT     = 4'd9,
        CMD_LEFT      = 4'd10,
        CMD_END       = 4'd11
    } cmd_t;

    typedef struct packed {
        logic loop_active;
        logic started;
        logic halted;
    } flags_t;

endpackage

[rtl/rcs_decode.sv]
// Combinational decoder of one opcode/operand pair for the command sequencer.
// Produces the actuator command and the updated sequencer state.
// Depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_decode #(
    parameter int ADDR_BITS = rcs_pkg::ADDR_BITS_DEFAULT
) (
    input  logic [rcs_pkg::BYTE_BITS-1:0]  opcode_byte,
    input  logic [rcs_pkg::BYTE_BITS-1:0]  operand_byte,
    input  logic [ADDR_BITS-1:0]           fetch_address,
    input  logic [ADDR_BITS-1:0]           loop_return_address,
    input  logic [rcs_pkg::BYTE_BITS-1:0]  loop_count,
    input  rcs_pkg::flags_t                flags,
    output rcs_pkg::cmd_t                  command,
    output logic [rcs_pkg::BYTE_BITS-1:0]  command_arg,
    output logic [rcs_pkg::DELAY_BITS-1:0] delay_ms,
    output logic [ADDR_BITS-1:0]           next_fetch_address,
    output logic [ADDR_BITS-1:0]           fetch_address_next,
    output logic [ADDR_BITS-1:0]           loop_return_address_next,
    output logic [rcs_pkg::BYTE_BITS-1:0]  loop_count_next,
    output rcs_pkg::flags_t                flags_next
);

    logic [rcs_pkg::BYTE_BITS-1:0]  count_work;
    logic [rcs_pkg::DELAY_BITS-1:0] arg_wide;

    assign arg_wide = rcs_pkg::DELAY_BITS'(operand_byte);

    always_comb
    begin
        command                  = rcs_pkg::CMD_NONE;
        command_arg              = '0;
        delay_ms                 = '0;
        next_fetch_address       = fetch_address;
        fetch_address_next       = fetch_address;
        loop_return_address_next = loop_return_address;
        count_work               = loop_count;
        flags_next               = flags;
        if (!flags.halted)
        begin
            if (!flags.started)
            begin
                if (opcode_byte == rcs_pkg::OP_START)
                begin
                    flags_next.started = 1'b1;
                end
            end
            else
            begin
                if (opcode_byte == rcs_pkg::OP_LOOP_BEGIN && !flags.loop_active)
                begin
                    count_work             = operand_byte;
                    flags_next.loop_active = 1'b1;
                end
                unique case (opcode_byte) inside
                    rcs_pkg::OP_WAIT:
                    begin
                        command  = rcs_pkg::CMD_WAIT;
                        delay_ms = (arg_wide << 4) + (arg_wide << 3) + arg_wide;
                    end
                    rcs_pkg::OP_LED_ON:
                    begin
                        command  = rcs_pkg::CMD_LED_ON;
                        delay_ms = rcs_pkg::LED_ON_MS;
                    end
                    rcs_pkg::OP_LED_OFF:
                    begin
                        command  = rcs_pkg::CMD_LED_OFF;
                        delay_ms = rcs_pkg::LED_OFF_MS;
                    end
                    rcs_pkg::OP_TONE:
                    begin
                        command     = rcs_pkg::CMD_TONE;
                        command_arg = operand_byte;
                    end
                    rcs_pkg::OP_TONE_STOP:
                    begin
                        command = rcs_pkg::CMD_TONE_STOP;
                    end
                    rcs_pkg::OP_STOP_A, rcs_pkg::OP_STOP_B:
                    begin
                        command = rcs_pkg::CMD_STOP;
                    end
                    rcs_pkg::OP_FWD:
                    begin
                        command     = rcs_pkg::CMD_FWD;
                        command_arg = operand_byte;
                    end
                    rcs_pkg::OP_REV:
                    begin
                        command     = rcs_pkg::CMD_REV;
                        command_arg = operand_byte;
                    end
                    rcs_pkg::OP_RIGHT:
                    begin
                        command     = rcs_pkg::CMD_RIGHT;
                        command_arg = rcs_pkg::FULL_DUTY;
                        delay_ms    = rcs_pkg::TURN_MS;
                    end
                    rcs_pkg::OP_LEFT:
                    begin
                        command     = rcs_pkg::CMD_LEFT;
                        command_arg = rcs_pkg::FULL_DUTY;
                        delay_ms    = rcs_pkg::TURN_MS;
                    end
                    rcs_pkg::OP_LOOP_BEGIN:
                    begin
                        loop_return_address_next = fetch_address;
                    end
                    rcs_pkg::OP_LOOP_END:
                    begin
                        if (count_work != '0)
                        begin
                            next_fetch_address = loop_return_address;
                            count_work         = count_work - rcs_pkg::BYTE_BITS'(1);
                        end
                        if (count_work == '0)
                        begin
                            flags_next.loop_active = 1'b0;
                        end
                    end
                    rcs_pkg::OP_END:
                    begin
                        command           = rcs_pkg::CMD_END;
                        flags_next.halted = 1'b1;
                    end
                    default:
                    begin
                        command = rcs_pkg::CMD_NONE;
                    end
                endcase
            end
            if (!flags_next.halted)
            begin
                fetch_address_next = next_fetch_address + ADDR_BITS'(2);
            end
        end
    end

    assign loop_count_next = count_work;

endmodule

[rtl/rcs_state.sv]
// Sequencer state registers: fetch and loop addresses, loop count and flags.
// A start address write restarts the sequencer from the new address.
// Depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_state #(
    parameter int ADDR_BITS = rcs_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rcs_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          update,
    input  logic [ADDR_BITS-1:0]          fetch_address_next,
    input  logic [ADDR_BITS-1:0]          loop_return_address_next,
    input  logic [rcs_pkg::BYTE_BITS-1:0] loop_count_next,
    input  rcs_pkg::flags_t               flags_next,
    output logic [ADDR_BITS-1:0]          fetch_address_reg,
    output logic [ADDR_BITS-1:0]          loop_return_address_reg,
    output logic [rcs_pkg::BYTE_BITS-1:0] loop_count_reg,
    output rcs_pkg::flags_t               flags_reg
);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_address_reg       <= ADDR_BITS'(2);
            loop_return_address_reg <= '0;
            loop_count_reg          <= '0;
            flags_reg               <= '0;
        end
        else if (cfg_we)
        begin
            fetch_address_reg       <= ADDR_BITS'(cfg_wdata) + ADDR_BITS'(2);
            loop_return_address_reg <= '0;
            loop_count_reg          <= '0;
            flags_reg               <= '0;
        end
        else if (update)
        begin
            fetch_address_reg       <= fetch_address_next;
            loop_return_address_reg <= loop_return_address_next;
            loop_count_reg          <= loop_count_next;
            flags_reg               <= flags_next;
        end
    end

endmodule

[rtl/robot_command_sequencer.sv]
// Top level of the robot command sequencer: input word register, decoder,
// state registers and result word register. Depends on rcs_pkg, rcs_decode
// and rcs_state.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_ready   opcode_byte, operand_byte
//   out       output     out_valid / out_ready command, command_arg, delay_ms,
//                                              next_fetch_address, program_done
//   cfg       input      cfg_we                cfg_wdata (start address)
//
// Each word is held in the input register and is decoded into the result
// register once the output register is free or being read, and one word is
// taken every cycle while the output side keeps up. The decode of a word and
// the update of the sequencer state happen on the same edge.
// Reset and a start address write both clear the loop state and flags; reset
// sets the fetch address to 2, a write to the start address plus 2. A stalled
// output holds its word while one more input word waits.
`timescale 1ns / 1ps

module robot_command_sequencer #(
    parameter int ADDR_BITS = rcs_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcs_pkg::CFG_BITS-1:0]   cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rcs_pkg::BYTE_BITS-1:0]  opcode_byte,
    input  logic [rcs_pkg::BYTE_BITS-1:0]  operand_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rcs_pkg::CMD_BITS-1:0]   command,
    output logic [rcs_pkg::BYTE_BITS-1:0]  command_arg,
    output logic [rcs_pkg::DELAY_BITS-1:0] delay_ms,
    output logic [rcs_pkg::OUT_ADDR_BITS-1:0] next_fetch_address,
    output logic                           program_done
);

    logic                           in_valid_reg;
    logic [rcs_pkg::BYTE_BITS-1:0]  opcode_reg;
    logic [rcs_pkg::BYTE_BITS-1:0]  operand_reg;
    logic                           out_valid_reg;
    logic [rcs_pkg::CMD_BITS-1:0]   command_reg;
    logic [rcs_pkg::BYTE_BITS-1:0]  command_arg_reg;
    logic [rcs_pkg::DELAY_BITS-1:0] delay_ms_reg;
    logic [rcs_pkg::OUT_ADDR_BITS-1:0] next_fetch_address_reg;
    logic                           program_done_reg;

    logic                           advance;
    logic                           in_take;

    logic [ADDR_BITS-1:0]           fetch_address_reg;
    logic [ADDR_BITS-1:0]           loop_return_address_reg;
    logic [rcs_pkg::BYTE_BITS-1:0]  loop_count_reg;
    rcs_pkg::flags_t                flags_reg;

    rcs_pkg::cmd_t                  dec_command;
    logic [rcs_pkg::BYTE_BITS-1:0]  dec_command_arg;
    logic [rcs_pkg::DELAY_BITS-1:0] dec_delay_ms;
    logic [ADDR_BITS-1:0]           dec_next_fetch_address;
    logic [ADDR_BITS-1:0]           fetch_address_next;
    logic [ADDR_BITS-1:0]           loop_return_address_next;
    logic [rcs_pkg::BYTE_BITS-1:0]  loop_count_next;
    rcs_pkg::flags_t                flags_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg  <= opcode_byte;
            operand_reg <= operand_byte;
        end
        if (advance)
        begin
            command_reg            <= dec_command;
            command_arg_reg        <= dec_command_arg;
            delay_ms_reg           <= dec_delay_ms;
            next_fetch_address_reg <= rcs_pkg::OUT_ADDR_BITS'(dec_next_fetch_address);
            program_done_reg       <= flags_next.halted;
        end
    end

    rcs_decode #(
        .ADDR_BITS (ADDR_BITS)
    ) u_decode (
        .opcode_byte              (opcode_reg),
        .operand_byte             (operand_reg),
        .fetch_address            (fetch_address_reg),
        .loop_return_address      (loop_return_address_reg),
        .loop_count               (loop_count_reg),
        .flags                    (flags_reg),
        .command                  (dec_command),
        .command_arg              (dec_command_arg),
        .delay_ms                 (dec_delay_ms),
        .next_fetch_address       (dec_next_fetch_address),
        .fetch_address_next       (fetch_address_next),
        .loop_return_address_next (loop_return_address_next),
        .loop_count_next          (loop_count_next),
        .flags_next               (flags_next)
    );

    rcs_state #(
        .ADDR_BITS (ADDR_BITS)
    ) u_state (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cfg_we                   (cfg_we),
        .cfg_wdata                (cfg_wdata),
        .update                   (advance),
        .fetch_address_next       (fetch_address_next),
        .loop_return_address_next (loop_return_address_next),
        .loop_count_next          (loop_count_next),
        .flags_next               (flags_next),
        .fetch_address_reg        (fetch_address_reg),
        .loop_return_address_reg  (loop_return_address_reg),
        .loop_count_reg           (loop_count_reg),
        .flags_reg                (flags_reg)
    );

    assign out_valid          = out_valid_reg;
    assign command            = command_reg;
    assign command_arg        = command_arg_reg;
    assign delay_ms           = delay_ms_reg;
    assign next_fetch_address = next_fetch_address_reg;
    assign program_done       = program_done_reg;

endmodule
